/* rtl/hilbert_curve_index_top_defines.svh */
// ----------------------------------------------------------------------------
// hilbert_curve_index_top_defines
// Assertion macros shared by the Hilbert index RTL.
// ----------------------------------------------------------------------------
`ifndef HILBERT_CURVE_INDEX_TOP_DEFINES_SVH
`define HILBERT_CURVE_INDEX_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause, outside reset.
`define HCI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause, outside reset.
`define HCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check what must hold in the cycle after reset is applied.
`define HCI_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hci_pkg.sv */
// ----------------------------------------------------------------------------
// hci_pkg
// Shared constants of the Hilbert index pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hci_pkg;

  // width of the coordinate ports
  localparam int INPUT_BITS       = 32;
  // width of the index port
  localparam int INDEX_BITS       = 64;
  // bit levels resolved in one pipeline stage
  localparam int LEVELS_PER_STAGE = 4;

endpackage

/* rtl/hci_level_stage.sv */
// ----------------------------------------------------------------------------
// hci_level_stage
// One pipeline stage that resolves a group of bit levels, top level first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_level_stage #(
  parameter int COORD_BITS  = 32,
  parameter int FIRST_LEVEL = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  input  logic [COORD_BITS-1:0] act_in,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [COORD_BITS-1:0] x_out,
  output logic [COORD_BITS-1:0] y_out,
  output logic [COORD_BITS-1:0] act_out
);

  localparam int LPS = hci_pkg::LEVELS_PER_STAGE;

  logic [COORD_BITS-1:0] xs [LPS+1];
  logic [COORD_BITS-1:0] ys [LPS+1];
  logic                  vld;
  logic [COORD_BITS-1:0] xr;
  logic [COORD_BITS-1:0] yr;
  logic [COORD_BITS-1:0] actr;

  assign xs[0] = x_in;
  assign ys[0] = y_in;

  for (genvar k = 0; k < LPS; k++) begin : g_lvl
    localparam int LVL = FIRST_LEVEL - k;
    if (LVL >= 1) begin : g_on
      localparam logic [COORD_BITS-1:0] LOW =
        COORD_BITS'((64'(1) << LVL) - 64'(1));
      logic [COORD_BITS-1:0] xa;
      logic [COORD_BITS-1:0] t;
      always_comb begin
        // x first: invert low bits of x where x holds the level bit
        xa = (act_in[LVL] && xs[k][LVL]) ? (xs[k] ^ LOW) : xs[k];
        t  = (xa ^ ys[k]) & LOW;
        if (!act_in[LVL]) begin
          xs[k+1] = xs[k];
          ys[k+1] = ys[k];
        end else if (ys[k][LVL]) begin
          xs[k+1] = xa ^ LOW;
          ys[k+1] = ys[k];
        end else begin
          // exchange low bits of x and y
          xs[k+1] = xa ^ t;
          ys[k+1] = ys[k] ^ t;
        end
      end
    end else begin : g_off
      assign xs[k+1] = xs[k];
      assign ys[k+1] = ys[k];
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      xr   <= xs[LPS];
      yr   <= ys[LPS];
      actr <= act_in;
    end
  end

  assign dn_valid = vld;
  assign x_out    = xr;
  assign y_out    = yr;
  assign act_out  = actr;

endmodule

/* rtl/hci_finish_stage.sv */
// ----------------------------------------------------------------------------
// hci_finish_stage
// Gray-codes the pair, applies the undo mask and interleaves the bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_finish_stage #(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [COORD_BITS-1:0]          x_in,
  input  logic [COORD_BITS-1:0]          y_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hci_pkg::INDEX_BITS-1:0] curve_index
);

  logic [COORD_BITS-1:0]          g;
  logic [COORD_BITS-1:0]          undo;
  logic [COORD_BITS-1:0]          xf;
  logic [COORD_BITS-1:0]          yf;
  logic [hci_pkg::INDEX_BITS-1:0] idx_next;
  logic                           vld;
  logic [hci_pkg::INDEX_BITS-1:0] idx;

  always_comb begin
    g = y_in ^ x_in;
    // undo bit j is the parity of the Gray-coded y bits above j
    for (int j = 0; j < COORD_BITS; j++) begin
      undo[j] = ^(g >> (j + 1));
    end
    xf = x_in ^ undo;
    yf = g ^ undo;
    idx_next = '0;
    for (int j = 0; j < COORD_BITS; j++) begin
      idx_next[2*j+1] = xf[j];
      idx_next[2*j]   = yf[j];
    end
  end

  assign up_ready = !vld || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      idx <= idx_next;
    end
  end

  assign out_valid   = vld;
  assign curve_index = idx;

endmodule

/* rtl/hilbert_curve_index_top.sv */
// ----------------------------------------------------------------------------
// hilbert_curve_index_top
// Two-dimensional Hilbert curve index of an unsigned point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with coord_x and coord_y. A request
//   is taken at a rising edge with in_valid high and in_stall low. Bits of
//   the coordinates at or above COORD_BITS are ignored.
//   Output channel: out_valid / out_stall with curve_index, right-aligned
//   in 2*(b+1) bits, where b is the top set bit of the larger coordinate.
//   Throughput: one request per cycle, sustained while out_stall is low.
//   Stages: NUM_STAGES + 2 register stages, where
//   NUM_STAGES = ceil((COORD_BITS-1)/4) level stages: one input stage that
//   finds the active levels, one stage per four bit levels of the
//   swap/invert chain, and one Gray/undo/interleave stage. A request passes
//   through them in that order, and out_valid rises once the finish stage
//   holds its index.
//   Reset clears every stage valid bit; no request is in flight after it.
//   Out stall: each stage holds while the next is full and stalled; empty
//   stages still fill, so bubbles close up and nothing is lost or repeated.
//   in_stall follows the pipeline's back pressure in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hilbert_curve_index_top_defines.svh"

module hilbert_curve_index_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hci_pkg::INPUT_BITS-1:0]  coord_x,
  input  logic [hci_pkg::INPUT_BITS-1:0]  coord_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hci_pkg::INDEX_BITS-1:0]  curve_index
);

  localparam int LPS        = hci_pkg::LEVELS_PER_STAGE;
  localparam int NUM_STAGES = (COORD_BITS - 1 + LPS - 1) / LPS;

  // input stage
  logic [COORD_BITS-1:0] xm;
  logic [COORD_BITS-1:0] ym;
  logic [COORD_BITS-1:0] act_next;
  logic                  s0_valid;
  logic                  s0_ready;

  // chain between stages: index 0 is the input stage; the ready entry past
  // the last level stage is the finish stage's
  logic                  lv_valid [NUM_STAGES+1];
  logic                  lv_ready [NUM_STAGES+2];
  logic [COORD_BITS-1:0] lv_x     [NUM_STAGES+1];
  logic [COORD_BITS-1:0] lv_y     [NUM_STAGES+1];
  logic [COORD_BITS-1:0] lv_act   [NUM_STAGES+1];

  // Back pressure into the last level stage comes from the finish stage.
  logic fin_ready;

  assign xm = coord_x[COORD_BITS-1:0];
  assign ym = coord_y[COORD_BITS-1:0];

  // Level L takes part only when some coordinate has a bit at or above L,
  // i.e. when L does not exceed the top set bit b.
  always_comb begin
    for (int l = 0; l < COORD_BITS; l++) begin
      act_next[l] = |((xm | ym) >> l);
    end
  end

  assign s0_ready = !s0_valid || lv_ready[1];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= in_valid;
    end
  end

  // Payload needs no reset: advance it only on an accepted request.
  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      lv_x[0]   <= xm;
      lv_y[0]   <= ym;
      lv_act[0] <= act_next;
    end
  end

  assign lv_valid[0] = s0_valid;
  assign lv_ready[0] = s0_ready;

  // The last level stage listens to the finish stage; every other stage
  // listens to the one after it.
  assign lv_ready[NUM_STAGES+1] = fin_ready;

  // Swap/invert chain, top level first, four levels per stage.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    hci_level_stage #(
      .COORD_BITS  (COORD_BITS),
      .FIRST_LEVEL (COORD_BITS - 1 - s * LPS)
    ) u_level (
      .clk      (clk),
      .rst      (rst),
      .up_valid (lv_valid[s]),
      .up_ready (lv_ready[s+1]),
      .x_in     (lv_x[s]),
      .y_in     (lv_y[s]),
      .act_in   (lv_act[s]),
      .dn_valid (lv_valid[s+1]),
      .dn_ready (lv_ready[s+2]),
      .x_out    (lv_x[s+1]),
      .y_out    (lv_y[s+1]),
      .act_out  (lv_act[s+1])
    );
  end

  hci_finish_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (lv_valid[NUM_STAGES]),
    .up_ready    (fin_ready),
    .x_in        (lv_x[NUM_STAGES]),
    .y_in        (lv_y[NUM_STAGES]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .curve_index (curve_index)
  );

  // Drop the level-active bits past the last level stage.
  logic unused_last_act;
  assign unused_last_act = ^lv_act[NUM_STAGES];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HCI_ASSERT_AFTER_RESET(a_reset_empty, clk, rst,
    !s0_valid && !out_valid, "pipeline not empty after reset")
  `HCI_ASSERT_SAME(a_empty_takes, clk, rst,
    !s0_valid, !in_stall, "input stalled while input stage empty")
  `HCI_ASSERT_NEXT(a_finish_loads, clk, rst,
    lv_valid[NUM_STAGES] && fin_ready, out_valid, "finish stage dropped a request")
  `HCI_ASSERT_SAME(a_index_width, clk, rst,
    out_valid, (curve_index >> (2 * COORD_BITS)) == '0, "index wider than 2*COORD_BITS")

endmodule

/* bench/tb_hilbert_curve_index_top.sv */
// ----------------------------------------------------------------------------
// tb_hilbert_curve_index_top
// Self-checking bench for the two-dimensional Hilbert index pipeline.
// ----------------------------------------------------------------------------
// Feeds points from a queue through a valid/stall driver and predicts each
// index in the bench. A clocked monitor compares every index that leaves the
// block against the oldest prediction. Both sides idle at random in
// stretches. The receiver holds off once for a long stretch so that the
// pipeline fills and stalls its input. The sender pauses twice until every
// predicted index has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hilbert_curve_index_top;

  localparam int COORD_BITS   = 32;
  localparam int RANDOM_ITEMS = 950;
  // receiver hold-off: start once this many requests were taken
  localparam int HOLD_AT      = 320;
  localparam int HOLD_CYCLES  = 150;
  // settle well past the pipeline latency
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [hci_pkg::INPUT_BITS-1:0] x;
    logic [hci_pkg::INPUT_BITS-1:0] y;
    int unsigned                    gap;
    bit                             drain;
  } point_req_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [hci_pkg::INPUT_BITS-1:0] coord_x = '0;
  logic [hci_pkg::INPUT_BITS-1:0] coord_y = '0;
  logic                           out_valid;
  logic                           out_stall;
  logic [hci_pkg::INDEX_BITS-1:0] curve_index;

  // receiver stall is the OR of the per-index wait and the long hold-off
  logic                  wait_stall = 1'b0;
  logic                  hold_stall = 1'b0;
  assign out_stall = wait_stall | hold_stall;

  point_req_t                     pending_points[$];
  logic [hci_pkg::INDEX_BITS-1:0] expected_index[$];

  int unsigned accepted_count     = 0;
  int unsigned checked_count      = 0;
  int unsigned error_count        = 0;
  int unsigned cycle_count        = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned drain_pauses       = 0;

  hilbert_curve_index_top #(
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .curve_index (curve_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Index prediction: find the top level, run the invert/swap chain from the
  // top level down to 1 (x before y at each level), Gray-code, apply the undo
  // mask, then interleave with the x bit leading each pair.
  // --------------------------------------------------------------------------
  function automatic logic [hci_pkg::INDEX_BITS-1:0] predict_index(
    input logic [hci_pkg::INPUT_BITS-1:0] cx,
    input logic [hci_pkg::INPUT_BITS-1:0] cy);
    logic [63:0] keep;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] big;
    logic [63:0] q;
    logic [63:0] low;
    logic [63:0] t;
    logic [63:0] undo;
    logic [63:0] h;
    int          top;
    int          lv;
    keep = (COORD_BITS >= 64) ? '1 : ((64'd1 << COORD_BITS) - 64'd1);
    x    = {32'd0, cx} & keep;
    y    = {32'd0, cy} & keep;
    big  = (x > y) ? x : y;
    top  = 0;
    for (lv = 0; lv < 64; lv++)
      if (big[lv]) top = lv;
    for (lv = top; lv >= 1; lv--) begin
      q   = 64'd1 << lv;
      low = q - 64'd1;
      if ((x & q) != 0) x = x ^ low;
      if ((y & q) != 0) begin
        x = x ^ low;
      end else begin
        t = (x ^ y) & low;
        x = x ^ t;
        y = y ^ t;
      end
    end
    y    = y ^ x;
    undo = '0;
    for (lv = top; lv >= 1; lv--)
      if (y[lv]) undo = undo ^ ((64'd1 << lv) - 64'd1);
    x = x ^ undo;
    y = y ^ undo;
    h = '0;
    for (lv = top; lv >= 0; lv--)
      h = {h[61:0], x[lv], y[lv]};
    return h;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: take the next point from the queue, wait out its gap, then offer
  // it and hold it steady until the block takes it. A drain point waits for
  // every predicted index to come back before it is taken from the queue.
  // --------------------------------------------------------------------------
  point_req_t  cur_point;
  bit          have_point = 1'b0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    logic drive_v;
    if (rst) begin
      in_valid   <= 1'b0;
      have_point = 1'b0;
    end else begin
      drive_v = in_valid;
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        expected_index.insert(expected_index.size(), predict_index(coord_x, coord_y));
        accepted_count++;
        drive_v = 1'b0;
      end
      if (!drive_v) begin
        if (!have_point && pending_points.size() > 0) begin
          if (!pending_points[0].drain || expected_index.size() == 0) begin
            cur_point  = pending_points.pop_front();
            have_point = 1'b1;
            gap_left   = cur_point.gap;
            if (cur_point.drain) drain_pauses++;
          end
        end
        if (have_point) begin
          if (gap_left == 0) begin
            coord_x    <= cur_point.x;
            coord_y    <= cur_point.y;
            drive_v    = 1'b1;
            have_point = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      in_valid <= drive_v;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each taken index against the oldest prediction, then draw
  // how long to stall before the next one. Of every three stretches of 90
  // indices, the first has no waiting and the next two draw random waits.
  // --------------------------------------------------------------------------
  int unsigned wait_left = 0;

  always @(posedge clk) begin
    logic [hci_pkg::INDEX_BITS-1:0] want;
    if (rst) begin
      wait_stall <= 1'b0;
      wait_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_index.size() == 0) begin
          report_mismatch($sformatf("unexpected index %h", curve_index));
        end else begin
          want = expected_index.pop_front();
          if (curve_index !== want)
            report_mismatch($sformatf("curve_index %h, predicted %h", curve_index, want));
        end
        checked_count++;
        wait_left = (((checked_count / 90) % 3) == 0) ? 0 : $urandom_range(0, 9);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      wait_stall <= (wait_left > 0);
    end
  end

  // Long receiver hold-off, counted here; the sender keeps offering meanwhile.
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_stall <= 1'b0;
      hold_done  = 1'b0;
      hold_left  = 0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES;
      hold_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left--;
    end else begin
      hold_left  = 0;
      hold_stall <= 1'b0;
    end
  end

  // Watchdog: end a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL hilbert_curve_index_top");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  function automatic point_req_t make_point(input logic [hci_pkg::INPUT_BITS-1:0] x,
                                            input logic [hci_pkg::INPUT_BITS-1:0] y,
                                            input int unsigned gap, input bit drain);
    point_req_t p;
    p.x     = x;
    p.y     = y;
    p.gap   = gap;
    p.drain = drain;
    return p;
  endfunction

  // Append one point to the driver's queue.
  task automatic queue_point(input logic [hci_pkg::INPUT_BITS-1:0] x,
                             input logic [hci_pkg::INPUT_BITS-1:0] y,
                             input int unsigned gap, input bit drain);
    pending_points.insert(pending_points.size(), make_point(x, y, gap, drain));
  endtask

  initial begin
    logic [hci_pkg::INPUT_BITS-1:0] keep;
    logic [hci_pkg::INPUT_BITS-1:0] rx;
    logic [hci_pkg::INPUT_BITS-1:0] ry;
    int unsigned                    gap;
    int unsigned                    w;
    int unsigned                    shape;
    int                             k;

    // Directed: origin, unit cells, extremes, top bit only, alternating
    // patterns, and points around level boundaries where x-before-y order
    // decides the quadrant.
    queue_point(32'h0000_0000, 32'h0000_0000, 0, 0);
    queue_point(32'h0000_0001, 32'h0000_0000, 0, 0);
    queue_point(32'h0000_0000, 32'h0000_0001, 0, 0);
    queue_point(32'h0000_0001, 32'h0000_0001, 0, 0);
    queue_point(32'h0000_0002, 32'h0000_0001, 0, 0);
    queue_point(32'h0000_0001, 32'h0000_0002, 0, 0);
    queue_point(32'h0000_0002, 32'h0000_0003, 0, 0);
    queue_point(32'h0000_0003, 32'h0000_0002, 0, 0);
    queue_point(32'h0000_0003, 32'h0000_0003, 0, 0);
    queue_point(32'h0000_0007, 32'h0000_0005, 0, 0);
    queue_point(32'h0000_0004, 32'h0000_0003, 0, 0);
    queue_point(32'h0000_0003, 32'h0000_0004, 0, 0);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    queue_point(32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
    queue_point(32'h0000_0000, 32'hFFFF_FFFF, 0, 0);
    queue_point(32'h8000_0000, 32'h0000_0000, 0, 0);
    queue_point(32'h0000_0000, 32'h8000_0000, 0, 0);
    queue_point(32'h8000_0000, 32'h8000_0000, 0, 0);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 0, 0);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA, 0, 0);
    queue_point(32'h0000_FFFF, 32'hFFFF_0000, 0, 0);

    // Random: size drawn first so every top level occurs; first point waits
    // for the directed results to drain, another drain pause comes later.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      w     = $urandom_range(0, 33);
      keep  = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
      rx    = $urandom() & keep;
      ry    = $urandom() & keep;
      shape = $urandom_range(0, 9);
      case (shape)
        0: ry = rx;
        1: ry = '0;
        2: rx = '0;
        default: ;
      endcase
      // keep the sender busy around the receiver hold-off
      if (k >= 280 && k < 480) gap = 0;
      else if (((k / 100) % 2) == 0) gap = 0;
      else gap = $urandom_range(0, 9);
      queue_point(rx, ry, gap, (k == 0) || (k == 700));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for all requests to be taken and every index to come back.
    while (pending_points.size() > 0 || have_point || in_valid || expected_index.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_index.size() > 0)
      report_mismatch($sformatf("%0d indices never arrived", expected_index.size()));

    $display("covered %0d points (all top levels, extremes, origin), %0d indices checked",
             accepted_count, checked_count);
    $display("input stalled %0d cycles under back pressure, %0d drain pauses",
             input_stall_cycles, drain_pauses);
    if (error_count == 0) begin
      $display("PASS hilbert_curve_index_top");
    end else begin
      $display("FAIL hilbert_curve_index_top");
    end
    $finish;
  end

endmodule
